>>> rtl/assert_macros.svh
// Assertion macros shared by the page-run allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be true at a clock edge
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> rtl/bpra_pkg.sv
// Shared types and constants of the bitmap page-run allocator
`default_nettype none

package bpra_pkg;

    localparam int POOL_PAGES_DEFAULT = 4096;
    localparam int PAGE_SHIFT = 12;
    localparam int WORD_BITS  = 32;
    localparam int BIT_W      = 5;
    localparam int CNT_W      = 13;
    localparam int PCNT_W     = 17;
    localparam int ADDR_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL = 1'b1;

    localparam logic [CNT_W-1:0] POOL_RESET = 13'd4096;

    // Outcome of scanning one bitmap word
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] end_bit;
        logic [CNT_W-1:0] next_carry;
    } scan_res_t;

endpackage

`default_nettype wire

>>> rtl/bpra_if.sv
// Request and response channel interfaces of the page-run allocator
`default_nettype none

interface bpra_req_if;
    import bpra_pkg::*;

    logic              valid;
    logic              ready;
    logic              command;
    logic [CNT_W-1:0]  page_count;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output command, output page_count, output address,
                    input ready);
    modport sink   (input valid, input command, input page_count, input address,
                    output ready);
endinterface

interface bpra_rsp_if;
    import bpra_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   start_address;

    modport source (output valid, output status, output start_address, input ready);
    modport sink   (input valid, input status, input start_address, output ready);
endinterface

`default_nettype wire

>>> rtl/bpra_bitmap_ram.sv
// Bitmap word memory: one write port, one registered read port
`default_nettype none

module bpra_bitmap_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  wire logic                           clk,
    input  wire logic                           we,
    input  wire logic [AW-1:0]                  wr_addr,
    input  wire logic [bpra_pkg::WORD_BITS-1:0] wr_data,
    input  wire logic [AW-1:0]                  rd_addr,
    output logic      [bpra_pkg::WORD_BITS-1:0] rd_data
);
    import bpra_pkg::*;

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    // Write and read one word per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/bpra_scan_unit.sv
// First-fit search over one 32-bit bitmap word, continuing a free run
`default_nettype none

module bpra_scan_unit (
    input  wire logic [bpra_pkg::WORD_BITS-1:0] used,
    input  wire logic [bpra_pkg::CNT_W-1:0]     carry,
    input  wire logic [bpra_pkg::CNT_W-1:0]     count,
    input  wire logic [bpra_pkg::WORD_BITS-1:0] win_mask,
    input  wire logic                           win_en,
    output bpra_pkg::scan_res_t                 res
);
    import bpra_pkg::*;

    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_BITS-1:0] win_hit;
    logic [BIT_W:0]       low_free;
    logic [BIT_W-1:0]     top_free;
    logic [BIT_W-1:0]     hit_bit;
    logic [CNT_W-1:0]     need_a;
    logic                 hit_a;

    assign free_bits = ~used;

    // Mark every bit that ends a window of count free bits inside the word
    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            win_hit[j] = win_en;
            for (int k = 0; k < WORD_BITS; k++)
            begin
                if (win_mask[k])
                begin
                    if (k > j)
                    begin
                        win_hit[j] = 1'b0;
                    end
                    else if (!free_bits[j-k])
                    begin
                        win_hit[j] = 1'b0;
                    end
                end
            end
        end
    end

    // Count free bits at the bottom and at the top, find the lowest window end
    always_comb
    begin
        low_free = 6'd32;
        hit_bit  = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (used[b])
            begin
                low_free = 6'(b);
            end
            if (win_hit[b])
            begin
                hit_bit = BIT_W'(b);
            end
        end
        top_free = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            if (used[b])
            begin
                top_free = BIT_W'(WORD_BITS - 1 - b);
            end
        end
    end

    // Run carried in from lower words completes at bit need_a
    assign need_a = count - carry - CNT_W'(1);
    assign hit_a  = need_a < {{(CNT_W-BIT_W-1){1'b0}}, low_free};

    always_comb
    begin
        res.found   = hit_a | (|win_hit);
        res.end_bit = hit_a ? need_a[BIT_W-1:0] : hit_bit;
        if (used == '0)
        begin
            res.next_carry = carry + CNT_W'(WORD_BITS);
        end
        else
        begin
            res.next_carry = {{(CNT_W-BIT_W){1'b0}}, top_free};
        end
    end

endmodule

`default_nettype wire

>>> rtl/bitmap_page_run_allocator.sv
// Top level of the bitmap page-run allocator: sequencer, registers, result stage
`default_nettype none
`include "assert_macros.svh"

// Page pool allocator over a used-bit bitmap kept in a 32-bit-wide memory.
// An allocate item scans the bitmap from page zero, one word per cycle through
// a single word-scan unit, for the lowest run of page_count free pages, then
// sets those bits in a read-modify-write pass over the words the run covers and
// returns base_address + page * 4096. A free item checks the address and the
// run against the pool and clears the bits the same way. One result per item.
// A zero page count answers ST_RANGE without touching the bitmap; an allocate
// on an empty pool or longer than the pool answers ST_NOSPACE without a scan,
// an allocate whose scan finds no run answers ST_NOSPACE, and a free outside
// the pool answers ST_RANGE after its check.
// One item is in work at a time; a finished result waits in the output
// register while the next item is taken. After reset a clearing pass writes
// POOL_PAGES/32 words, rounded up, before the first item is taken.
module bitmap_page_run_allocator #(
    parameter int POOL_PAGES = bpra_pkg::POOL_PAGES_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [bpra_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bpra_pkg::CFG_DATA_W-1:0] cfg_data,
    bpra_req_if.sink                             request,
    bpra_rsp_if.source                           response
);
    import bpra_pkg::*;

    localparam int WORDS   = (POOL_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int POS_W   = WADDR_W + BIT_W;
    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORDS - 1);
    localparam logic [PCNT_W-1:0]  PAGES_MAX = PCNT_W'(POOL_PAGES);

    // Sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_MARK  = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [ADDR_W-1:0]     base_reg;
    logic [CNT_W-1:0]      pool_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  proc_valid_reg, proc_valid_next;
    logic [WADDR_W-1:0]    walk_addr_reg, walk_addr_next;
    logic [WADDR_W-1:0]    proc_addr_reg, proc_addr_next;
    logic [WADDR_W-1:0]    stop_addr_reg, stop_addr_next;

    logic                  cmd_reg, cmd_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [PCNT_W-1:0]     pages_reg, pages_next;
    logic [ADDR_W:0]       diff_reg, diff_next;
    logic [BIT_W-1:0]      last_bit_reg, last_bit_next;
    logic [CNT_W-1:0]      carry_reg, carry_next;
    logic [WORD_BITS-1:0]  win_mask_reg, win_mask_next;
    logic                  win_en_reg, win_en_next;
    logic [PCNT_W-1:0]     first_reg, first_next;
    logic [PCNT_W-1:0]     end_reg, end_next;
    logic                  set_reg, set_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [ADDR_W-1:0]     out_start_reg, out_start_next;

    logic                  in_fire;
    logic                  out_load;
    logic [PCNT_W-1:0]     pool_ext;
    logic [PCNT_W-1:0]     active_pages;
    logic [PCNT_W-1:0]     active_m1;
    logic [PCNT_W-1:0]     count_ext;
    logic [PCNT_W+3:0]     run_top;
    logic [PCNT_W+3:0]     pages_wide;
    logic [WORD_BITS-1:0]  rd_data;
    logic [WORD_BITS-1:0]  pool_mask;
    logic [WORD_BITS-1:0]  scan_used;
    scan_res_t             scan_res;
    logic [PCNT_W-1:0]     found_end;
    logic [PCNT_W-1:0]     found_first;
    logic [WADDR_W-1:0]    first_word;
    logic [BIT_W-1:0]      mark_lo;
    logic [BIT_W-1:0]      mark_hi;
    logic [WORD_BITS-1:0]  mark_mask;
    logic                  ram_we;
    logic [WADDR_W-1:0]    ram_wr_addr;
    logic [WORD_BITS-1:0]  ram_wr_data;

    assign in_fire = request.valid && request.ready;
    assign request.ready = (state_reg == S_IDLE);

    // Pool size, saturated to the storage
    assign pool_ext     = {{(PCNT_W-CNT_W){1'b0}}, pool_reg};
    assign active_pages = (pool_ext > PAGES_MAX) ? PAGES_MAX : pool_ext;
    assign active_m1    = active_pages - PCNT_W'(1);
    assign count_ext    = {{(PCNT_W-CNT_W){1'b0}}, request.page_count};

    // Free range check: page index plus count against the pool
    assign run_top    = {1'b0, diff_reg[ADDR_W-1:PAGE_SHIFT]}
                        + (PCNT_W+4)'(count_reg);
    assign pages_wide = (PCNT_W+4)'(pages_reg);

    // Treat bits past the pool as used
    assign pool_mask = (proc_addr_reg == stop_addr_reg)
                       ? ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - last_bit_reg))
                       : {WORD_BITS{1'b1}};
    assign scan_used = rd_data | ~pool_mask;

    bpra_scan_unit u_scan (
        .used       (scan_used),
        .carry      (carry_reg),
        .count      (count_reg),
        .win_mask   (win_mask_reg),
        .win_en     (win_en_reg),
        .res        (scan_res)
    );

    assign found_end   = {{(PCNT_W-POS_W){1'b0}}, proc_addr_reg, scan_res.end_bit};
    assign found_first = found_end - {{(PCNT_W-CNT_W){1'b0}}, count_reg} + PCNT_W'(1);

    // Bits of the run inside the word being written back
    assign first_word = first_reg[POS_W-1:BIT_W];
    assign mark_lo    = (proc_addr_reg == first_word) ? first_reg[BIT_W-1:0] : '0;
    assign mark_hi    = (proc_addr_reg == stop_addr_reg) ? end_reg[BIT_W-1:0]
                                                         : BIT_W'(WORD_BITS - 1);
    assign mark_mask  = ({WORD_BITS{1'b1}} << mark_lo)
                        & ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - mark_hi));

    assign out_load = (state_reg == S_RESP) && (!out_valid_reg || response.ready);

    bpra_bitmap_ram #(
        .DEPTH (WORDS),
        .AW    (WADDR_W)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (walk_addr_reg),
        .rd_data (rd_data)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        walk_addr_next  = walk_addr_reg;
        proc_addr_next  = proc_addr_reg;
        proc_valid_next = proc_valid_reg;
        stop_addr_next  = stop_addr_reg;
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        pages_next      = pages_reg;
        diff_next       = diff_reg;
        last_bit_next   = last_bit_reg;
        carry_next      = carry_reg;
        win_mask_next   = win_mask_reg;
        win_en_next     = win_en_reg;
        first_next      = first_reg;
        end_next        = end_reg;
        set_next        = set_reg;
        status_next     = status_reg;
        ram_we          = 1'b0;
        ram_wr_addr     = proc_addr_reg;
        ram_wr_data     = set_reg ? (rd_data | mark_mask) : (rd_data & ~mark_mask);

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = walk_addr_reg;
                ram_wr_data = '0;
                if (walk_addr_reg == LAST_WORD)
                begin
                    walk_addr_next = '0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    walk_addr_next = walk_addr_reg + WADDR_W'(1);
                end
            end

            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next        = request.command;
                    count_next      = request.page_count;
                    pages_next      = active_pages;
                    diff_next       = {1'b0, request.address} - {1'b0, base_reg};
                    carry_next      = '0;
                    win_en_next     = request.page_count <= CNT_W'(WORD_BITS);
                    win_mask_next   = (request.page_count >= CNT_W'(WORD_BITS))
                                      ? {WORD_BITS{1'b1}}
                                      : ~({WORD_BITS{1'b1}} << request.page_count[BIT_W-1:0]);
                    walk_addr_next  = '0;
                    proc_valid_next = 1'b0;
                    stop_addr_next  = active_m1[POS_W-1:BIT_W];
                    last_bit_next   = active_m1[BIT_W-1:0];
                    set_next        = 1'b1;
                    priority if (request.page_count == '0)
                    begin
                        status_next = ST_RANGE;
                        state_next  = S_RESP;
                    end
                    else if (request.command == CMD_FREE)
                    begin
                        state_next = S_CHECK;
                    end
                    else if (active_pages == '0 || count_ext > active_pages)
                    begin
                        status_next = ST_NOSPACE;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_CHECK:
            begin
                if (diff_reg[ADDR_W] || run_top > pages_wide)
                begin
                    status_next = ST_RANGE;
                    state_next  = S_RESP;
                end
                else
                begin
                    first_next      = diff_reg[PAGE_SHIFT+PCNT_W-1:PAGE_SHIFT];
                    end_next        = run_top[PCNT_W-1:0] - PCNT_W'(1);
                    walk_addr_next  = diff_reg[PAGE_SHIFT+POS_W-1:PAGE_SHIFT+BIT_W];
                    stop_addr_next  = end_next[POS_W-1:BIT_W];
                    proc_valid_next = 1'b0;
                    set_next        = 1'b0;
                    state_next      = S_MARK;
                end
            end

            S_SCAN:
            begin
                // Advance the read pointer; the word read last cycle is in rd_data
                proc_addr_next  = walk_addr_reg;
                proc_valid_next = 1'b1;
                if (walk_addr_reg != stop_addr_reg)
                begin
                    walk_addr_next = walk_addr_reg + WADDR_W'(1);
                end
                if (proc_valid_reg)
                begin
                    priority if (scan_res.found)
                    begin
                        end_next        = found_end;
                        first_next      = found_first;
                        walk_addr_next  = found_first[POS_W-1:BIT_W];
                        stop_addr_next  = found_end[POS_W-1:BIT_W];
                        proc_valid_next = 1'b0;
                        state_next      = S_MARK;
                    end
                    else if (proc_addr_reg == stop_addr_reg)
                    begin
                        status_next = ST_NOSPACE;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        carry_next = scan_res.next_carry;
                    end
                end
            end

            S_MARK:
            begin
                // Read the next word while writing back the current one
                proc_addr_next  = walk_addr_reg;
                proc_valid_next = 1'b1;
                if (walk_addr_reg != stop_addr_reg)
                begin
                    walk_addr_next = walk_addr_reg + WADDR_W'(1);
                end
                if (proc_valid_reg)
                begin
                    ram_we = 1'b1;
                    if (proc_addr_reg == stop_addr_reg)
                    begin
                        status_next = ST_OK;
                        state_next  = S_RESP;
                    end
                end
            end

            S_RESP:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = status_reg;
            if (status_reg == ST_OK && cmd_reg == CMD_ALLOC)
            begin
                out_start_next = base_reg
                                 + {{(ADDR_W-PCNT_W-PAGE_SHIFT){1'b0}}, first_reg,
                                    {PAGE_SHIFT{1'b0}}};
            end
            else
            begin
                out_start_next = '0;
            end
        end
        else if (response.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign response.valid         = out_valid_reg;
    assign response.status        = out_status_reg;
    assign response.start_address = out_start_reg;

    // Control state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            walk_addr_reg  <= '0;
            proc_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            base_reg       <= '0;
            pool_reg       <= POOL_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            walk_addr_reg  <= walk_addr_next;
            proc_valid_reg <= proc_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_write && cfg_index == REG_BASE)
            begin
                base_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == REG_POOL)
            begin
                pool_reg <= cfg_data[CNT_W-1:0];
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        proc_addr_reg  <= proc_addr_next;
        stop_addr_reg  <= stop_addr_next;
        cmd_reg        <= cmd_next;
        count_reg      <= count_next;
        pages_reg      <= pages_next;
        diff_reg       <= diff_next;
        last_bit_reg   <= last_bit_next;
        carry_reg      <= carry_next;
        win_mask_reg   <= win_mask_next;
        win_en_reg     <= win_en_next;
        first_reg      <= first_next;
        end_reg        <= end_next;
        set_reg        <= set_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_start_reg  <= out_start_next;
    end

    `ASSERT_CLK(a_accept_leaves_idle, clk, rst_n,
        in_fire |=> (state_reg != S_IDLE),
        "item accepted but sequencer stayed idle")
    `ASSERT_CLK(a_write_phase, clk, rst_n,
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_MARK),
        "bitmap written outside clear or mark")
    `ASSERT_CLK(a_mark_in_run, clk, rst_n,
        (ram_we && state_reg == S_MARK)
            |-> (proc_addr_reg >= first_word && proc_addr_reg <= stop_addr_reg),
        "bitmap write outside the run")
    `ASSERT_CLK(a_start_only_ok, clk, rst_n,
        (out_valid_reg && out_start_reg != '0) |-> (out_status_reg == ST_OK),
        "start address on a failed item")

endmodule

`default_nettype wire
